FILE: design/tdm_sample_bit_serializer_top_defines.svh
// assertion macros for the tdm sample bit serializer checker
// expects clk and rst_n in the scope where a macro is used
`ifndef TDM_SAMPLE_BIT_SERIALIZER_TOP_DEFINES_SVH
`define TDM_SAMPLE_BIT_SERIALIZER_TOP_DEFINES_SVH

// same-cycle implication
`define TSBS_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TSBS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tsbs_pkg.sv
// shared types and constants of the tdm sample bit serializer
// no dependencies
package tsbs_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int EPP_W      = 9;
    localparam int PERIOD_W   = 32;
    localparam int FCH_W      = 3;
    localparam int LOAD_EL_W  = 8;
    localparam int LOAD_CH_W  = 3;
    localparam int SAMPLE_W   = 32;
    localparam int S_TDATA_W  = 48;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 8;

    localparam logic [EPP_W-1:0]    EPP_RESET  = 9'd256;
    localparam logic [FCH_W-1:0]    FCH_RESET  = 3'd7;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = 32'hFFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ELEMENTS_PER_PERIOD,
        CFG_EVENT_START_PERIOD,
        CFG_EVENT_END_PERIOD,
        CFG_FINAL_CHANNEL_ID
    } cfg_index_t;

    typedef enum logic {
        CMD_LOAD,
        CMD_TICK
    } cmd_t;

    typedef enum logic {
        TBL_NORMAL,
        TBL_EVENT
    } table_t;

endpackage

FILE: design/tdm_sample_bit_serializer_top.sv
// tdm sample bit serializer, top level
// depends on tsbs_pkg
//
// usage
//   s_* channel takes words: a load (s_tuser[0] low) writes one sample into
//   the normal or event table (s_tuser[1]); a tick (s_tuser[0] high) emits
//   one serial bit on the m_* channel and advances bit, channel, element and
//   period counters. loads give no output word.
//   m_tdata[0] is the bit (msb of each sample first), m_tlast marks bit 0 of
//   a sample, m_tuser marks the configured final channel.
//   cfg_we/cfg_index/cfg_data write the four settings while the block idles.
// timing
//   a tick's bit is registered by the synchronous table read, then by the
//   output register. one word is taken every cycle while s_tready is high.
// reset
//   counters restart at the msb of channel 0, element 0, period 0, normal
//   table; settings return to their defaults; table contents are not cleared.
// stall
//   with m_tready low the output holds; one more tick may sit in the read
//   stage, after which s_tready drops until the output moves.
module tdm_sample_bit_serializer_top
    import tsbs_pkg::*;
#(
    parameter int CHANNELS     = 8,
    parameter int MAX_ELEMENTS = 256,
    parameter int SAMPLE_BITS  = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // load_element[7:0], load_channel[10:8], sample_value[42:11], zero fill
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // command[0], table_select[1]
    input  logic [S_TUSER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // data_bit[0], zero fill
    output logic [M_TDATA_W-1:0]  m_tdata,
    // word_done
    output logic                  m_tlast,
    // channel_done
    output logic                  m_tuser
);

    localparam int DEPTH  = CHANNELS * MAX_ELEMENTS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int EL_W   = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int LIM_C  = $clog2(MAX_ELEMENTS + 1);
    localparam int LIM_W  = (LIM_C > EPP_W) ? LIM_C : EPP_W;
    localparam int PW     = LIM_W + 5;
    localparam int BP_W   = $clog2(SAMPLE_BITS);
    localparam int CMP_W  = (CH_W > FCH_W) ? CH_W : FCH_W;
    localparam int LCH_W  = LOAD_CH_W + 2;

    logic [SAMPLE_BITS-1:0] nrm_mem [DEPTH];
    logic [SAMPLE_BITS-1:0] evt_mem [DEPTH];

    logic [EPP_W-1:0]       epp_reg;
    logic [PERIOD_W-1:0]    ev_start_reg;
    logic [PERIOD_W-1:0]    ev_end_reg;
    logic [FCH_W-1:0]       fch_reg;

    logic [BP_W-1:0]        bp_reg,     bp_next;
    logic [CH_W-1:0]        ch_reg,     ch_next;
    logic [EL_W-1:0]        el_reg,     el_next;
    logic [PERIOD_W-1:0]    period_reg, period_next;
    logic                   use_reg,    use_next;

    logic                   p1_valid_reg;
    logic [BP_W-1:0]        p1_bp_reg;
    logic                   p1_wdone_reg;
    logic                   p1_cdone_reg;
    logic                   p1_use_reg;
    logic [SAMPLE_BITS-1:0] nrm_rd_reg;
    logic [SAMPLE_BITS-1:0] evt_rd_reg;

    logic                   out_valid_reg;
    logic                   out_bit_reg;
    logic                   out_wdone_reg;
    logic                   out_cdone_reg;

    cmd_t                   cmd;
    table_t                 tsel;
    logic [LOAD_EL_W-1:0]   ld_el;
    logic [LOAD_CH_W-1:0]   ld_ch;
    logic [SAMPLE_W-1:0]    ld_val;
    logic                   in_fire;
    logic                   tick_fire;
    logic                   load_ok;
    logic                   nrm_we;
    logic                   evt_we;
    logic [PW-1:0]          wr_addr_w;
    logic [PW-1:0]          rd_addr_w;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic                   p1_adv;
    logic [LIM_W-1:0]       limit;
    logic [LIM_W-1:0]       el_inc;
    logic                   ch_wrap;
    logic                   wdone;
    logic                   cdone;
    logic [SAMPLE_BITS-1:0] sel_word;

    // input unpacking
    assign cmd    = cmd_t'(s_tuser[0]);
    assign tsel   = table_t'(s_tuser[1]);
    assign ld_el  = s_tdata[7:0];
    assign ld_ch  = s_tdata[10:8];
    assign ld_val = s_tdata[42:11];

    assign p1_adv    = !out_valid_reg || m_tready;
    assign s_tready  = !p1_valid_reg || p1_adv;
    assign in_fire   = s_tvalid && s_tready;
    assign tick_fire = in_fire && (cmd == CMD_TICK);

    assign load_ok = (LIM_W'(ld_el) < LIM_W'(MAX_ELEMENTS))
                  && ({2'b00, ld_ch} < LCH_W'(CHANNELS));
    assign nrm_we  = in_fire && (cmd == CMD_LOAD) && load_ok && (tsel == TBL_NORMAL);
    assign evt_we  = in_fire && (cmd == CMD_LOAD) && load_ok && (tsel == TBL_EVENT);

    assign wr_addr_w = PW'(ld_el) * PW'(CHANNELS) + PW'(ld_ch);
    assign rd_addr_w = PW'(el_reg) * PW'(CHANNELS) + PW'(ch_reg);
    assign wr_addr   = wr_addr_w[AW-1:0];
    assign rd_addr   = rd_addr_w[AW-1:0];

    assign wdone = (bp_reg == '0);
    assign cdone = (CMP_W'(ch_reg) == CMP_W'(fch_reg));

    // counter advance
    always_comb
    begin
        if (epp_reg == '0)
        begin
            limit = LIM_W'(1);
        end
        else if (LIM_W'(epp_reg) > LIM_W'(MAX_ELEMENTS))
        begin
            limit = LIM_W'(MAX_ELEMENTS);
        end
        else
        begin
            limit = LIM_W'(epp_reg);
        end

        ch_wrap = 1'b0;
        if (wdone)
        begin
            bp_next = BP_W'(SAMPLE_BITS - 1);
            if (ch_reg == CH_W'(CHANNELS - 1))
            begin
                ch_next = '0;
                ch_wrap = 1'b1;
            end
            else
            begin
                ch_next = ch_reg + CH_W'(1);
            end
        end
        else
        begin
            bp_next = bp_reg - BP_W'(1);
            ch_next = ch_reg;
        end

        el_inc = ch_wrap ? LIM_W'(el_reg) + LIM_W'(1) : LIM_W'(el_reg);
        if (el_inc >= limit)
        begin
            el_next = '0;
            period_next = (period_reg == PERIOD_MAX) ? period_reg
                                                     : period_reg + PERIOD_W'(1);
        end
        else
        begin
            el_next = el_inc[EL_W-1:0];
            period_next = period_reg;
        end

        use_next = (period_next >= ev_start_reg) && (period_next < ev_end_reg);
    end

    // settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epp_reg      <= EPP_RESET;
            ev_start_reg <= '0;
            ev_end_reg   <= '0;
            fch_reg      <= FCH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ELEMENTS_PER_PERIOD: epp_reg      <= cfg_data[EPP_W-1:0];
                CFG_EVENT_START_PERIOD:  ev_start_reg <= cfg_data[PERIOD_W-1:0];
                CFG_EVENT_END_PERIOD:    ev_end_reg   <= cfg_data[PERIOD_W-1:0];
                CFG_FINAL_CHANNEL_ID:    fch_reg      <= cfg_data[FCH_W-1:0];
                default:                 epp_reg      <= epp_reg;
            endcase
        end
    end

    // playback counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bp_reg     <= BP_W'(SAMPLE_BITS - 1);
            ch_reg     <= '0;
            el_reg     <= '0;
            period_reg <= '0;
            use_reg    <= 1'b0;
        end
        else if (tick_fire)
        begin
            bp_reg     <= bp_next;
            ch_reg     <= ch_next;
            el_reg     <= el_next;
            period_reg <= period_next;
            use_reg    <= use_next;
        end
    end

    // sample tables
    always_ff @(posedge clk)
    begin
        if (nrm_we)
        begin
            nrm_mem[wr_addr] <= ld_val[SAMPLE_BITS-1:0];
        end
        if (tick_fire)
        begin
            nrm_rd_reg <= nrm_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_we)
        begin
            evt_mem[wr_addr] <= ld_val[SAMPLE_BITS-1:0];
        end
        if (tick_fire)
        begin
            evt_rd_reg <= evt_mem[rd_addr];
        end
    end

    // read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (tick_fire)
        begin
            p1_valid_reg <= 1'b1;
        end
        else if (p1_adv)
        begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            p1_bp_reg    <= bp_reg;
            p1_wdone_reg <= wdone;
            p1_cdone_reg <= cdone;
            p1_use_reg   <= use_reg;
        end
    end

    assign sel_word = p1_use_reg ? evt_rd_reg : nrm_rd_reg;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (p1_valid_reg && p1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_valid_reg && p1_adv)
        begin
            out_bit_reg   <= sel_word[p1_bp_reg];
            out_wdone_reg <= p1_wdone_reg;
            out_cdone_reg <= p1_cdone_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, out_bit_reg};
    assign m_tlast  = out_wdone_reg;
    assign m_tuser  = out_cdone_reg;

endmodule

FILE: design/tsbs_checker.sv
// port-level checker for the tdm sample bit serializer, bound to the top level
// depends on tsbs_pkg and tdm_sample_bit_serializer_top_defines.svh
`include "tdm_sample_bit_serializer_top_defines.svh"

module tsbs_checker
    import tsbs_pkg::*;
#(
    parameter int SAMPLE_BITS = 32
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [S_TUSER_W-1:0]  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic                  m_tlast,
    input logic                  m_tuser
);

    localparam int BC_W = $clog2(SAMPLE_BITS);

    logic            tick_fire;
    logic            out_fire;
    logic [2:0]      pend_reg;
    logic [BC_W-1:0] bc_reg;

    assign tick_fire = s_tvalid && s_tready && (cmd_t'(s_tuser[0]) == CMD_TICK);
    assign out_fire  = m_tvalid && m_tready;

    // ticks accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (tick_fire && !out_fire)
        begin
            pend_reg <= pend_reg + 3'd1;
        end
        else if (out_fire && !tick_fire)
        begin
            pend_reg <= pend_reg - 3'd1;
        end
    end

    // position of the next delivered bit within its word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bc_reg <= '0;
        end
        else if (out_fire)
        begin
            bc_reg <= (bc_reg == BC_W'(SAMPLE_BITS - 1)) ? '0 : bc_reg + BC_W'(1);
        end
    end

    `TSBS_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser),
        "output word changed while stalled")

    `TSBS_ASSERT(a_no_spurious, out_fire, pend_reg != 3'd0,
        "output word without a pending tick")

    `TSBS_ASSERT(a_last_bit, out_fire, m_tlast == (bc_reg == BC_W'(SAMPLE_BITS - 1)),
        "tlast not on the last bit of a sample")

    `TSBS_ASSERT(a_ready_cause, !s_tready, m_tvalid && !m_tready,
        "input blocked without an output stall")

endmodule

bind tdm_sample_bit_serializer_top tsbs_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_tsbs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
